### design/hass_pkg.sv
// Shared types and constants for the health-aware server selector.
`default_nettype none
package hass_pkg;

    localparam int GROUPS      = 64;
    localparam int GROUP_W     = $clog2(GROUPS);
    localparam int MAX_SERVERS = 16;
    localparam int SRV_W       = $clog2(MAX_SERVERS);
    localparam int CNT_W       = SRV_W + 1;
    localparam int HASH_W      = 32;

    // hash remainder: hash bits folded in per cycle
    localparam int MOD_DIGIT   = 4;
    localparam int MOD_STEPS   = HASH_W / MOD_DIGIT;
    localparam int MOD_STEP_W  = $clog2(MOD_STEPS);

    localparam logic [1:0] MODE_RR       = 2'd0;
    localparam logic [1:0] MODE_FAILOVER = 2'd1;
    localparam logic [1:0] MODE_STICKY   = 2'd2;

    typedef struct packed {
        logic [MAX_SERVERS-1:0] ok;
        logic [MAX_SERVERS-1:0] fade;
        logic [MAX_SERVERS-1:0] up;
        logic [MAX_SERVERS-1:0] mfade;
    } health_t;

    typedef struct packed {
        logic             start;
        logic [SRV_W-1:0] start_idx;
        logic [CNT_W-1:0] cnt;
        logic             allow_first;
        logic             allow_rest;
    } scan_cmd_t;

    typedef struct packed {
        logic             done;
        logic [SRV_W-1:0] sel;
        logic             fb;
    } scan_res_t;

    typedef struct packed {
        logic              start;
        logic [HASH_W-1:0] hash;
        logic [CNT_W-1:0]  cnt;
    } mod_cmd_t;

    typedef struct packed {
        logic             done;
        logic [SRV_W-1:0] rem;
    } mod_res_t;

endpackage
`default_nettype wire

### design/hass_mod.sv
// Iterative hash remainder: four hash bits per cycle through a compare/subtract chain.
`default_nettype none
module hass_mod
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hass_pkg::mod_cmd_t cmd,
    output hass_pkg::mod_res_t     res
);

    logic                                busy_reg;
    logic [hass_pkg::MOD_STEP_W-1:0]     step_reg;
    logic [hass_pkg::HASH_W-1:0]         sh_reg;
    logic [hass_pkg::CNT_W-1:0]          cnt_reg;
    logic [hass_pkg::SRV_W-1:0]          rem_reg;
    logic [hass_pkg::SRV_W-1:0]          rem_next;
    logic                                last;

    always_comb
    begin
        logic [hass_pkg::CNT_W-1:0] t;
        t = {1'b0, rem_reg};
        for (int i = 0; i < hass_pkg::MOD_DIGIT; i++)
        begin
            t = {t[hass_pkg::SRV_W-1:0], sh_reg[hass_pkg::HASH_W-1-i]};
            if (t >= cnt_reg)
            begin
                t = t - cnt_reg;
            end
        end
        rem_next = t[hass_pkg::SRV_W-1:0];
    end

    assign last = busy_reg
        && (step_reg == hass_pkg::MOD_STEP_W'(hass_pkg::MOD_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (cmd.start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            busy_reg <= !last;
            step_reg <= step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            sh_reg  <= cmd.hash;
            cnt_reg <= cmd.cnt;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            sh_reg  <= sh_reg << hass_pkg::MOD_DIGIT;
            rem_reg <= rem_next;
        end
    end

    assign res.done = last;
    assign res.rem  = rem_next;

endmodule
`default_nettype wire

### design/hass_scan.sv
// Health scan: checks one server per cycle, wrapping from a start index.
`default_nettype none
module hass_scan
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire hass_pkg::scan_cmd_t cmd,
    input  wire hass_pkg::health_t   masks,
    output hass_pkg::scan_res_t     res
);

    logic                       busy_reg;
    logic [hass_pkg::SRV_W-1:0] idx_reg;
    logic [hass_pkg::SRV_W-1:0] start_reg;
    logic [hass_pkg::SRV_W-1:0] step_reg;
    logic [hass_pkg::CNT_W-1:0] cnt_reg;
    logic                       allow_first_reg;
    logic                       allow_rest_reg;
    logic                       allow;
    logic                       fail_good;
    logic                       mon_good;
    logic                       hit;
    logic                       last;
    logic [hass_pkg::CNT_W-1:0] idx_inc;

    assign allow     = (step_reg == '0) ? allow_first_reg : allow_rest_reg;
    assign fail_good = masks.ok[idx_reg] | (allow & masks.fade[idx_reg]);
    assign mon_good  = masks.up[idx_reg] & (allow | ~masks.mfade[idx_reg]);
    assign hit       = busy_reg & fail_good & mon_good;
    assign last      = ({1'b0, step_reg} + 1'b1) == cnt_reg;
    assign idx_inc   = {1'b0, idx_reg} + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            busy_reg <= 1'b1;
        end
        else if (busy_reg && (hit || last))
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            idx_reg         <= cmd.start_idx;
            start_reg       <= cmd.start_idx;
            cnt_reg         <= cmd.cnt;
            allow_first_reg <= cmd.allow_first;
            allow_rest_reg  <= cmd.allow_rest;
            step_reg        <= '0;
        end
        else if (busy_reg)
        begin
            idx_reg  <= (idx_inc >= cnt_reg) ? '0 : idx_inc[hass_pkg::SRV_W-1:0];
            step_reg <= step_reg + 1'b1;
        end
    end

    assign res.done = busy_reg & (hit | last);
    assign res.sel  = hit ? idx_reg : start_reg;
    assign res.fb   = !hit;

endmodule
`default_nettype wire

### design/health_aware_server_selector_unit.sv
// Top level: request sequencer, round-robin pointer memory and result register.
// Flow: a request is accepted, prepared, then k servers are scanned (k = 1..16);
// sticky requests with a nonzero hash first wait for the hash remainder, and a group
// of one skips the scan. One request at a time; the next one is accepted the cycle
// after the result is loaded into the output register.
// Reset: pointer valid bits clear at once, so every group pointer reads as zero.
`default_nettype none
module health_aware_server_selector_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [5:0]  group_id,
    input  wire logic [4:0]  server_count,
    input  wire logic [1:0]  mode,
    input  wire logic [31:0] client_hash,
    input  wire logic [15:0] fail_ok_mask,
    input  wire logic [15:0] fail_fade_mask,
    input  wire logic [15:0] monitor_up_mask,
    input  wire logic [15:0] monitor_fade_mask,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       server_index,
    output logic             fallback_used
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_OUT
    } state_t;

    state_t                           state_reg;
    logic [hass_pkg::GROUP_W-1:0]     grp_reg;
    logic [hass_pkg::CNT_W-1:0]       cnt_reg;
    logic [1:0]                       mode_reg;
    logic                             sticky_reg;
    hass_pkg::health_t                masks_reg;
    logic [hass_pkg::SRV_W-1:0]       ptr_rd_reg;
    logic                             ptr_vld_reg;
    logic [hass_pkg::SRV_W-1:0]       res_sel_reg;
    logic                             res_fb_reg;
    logic                             out_valid_reg;
    logic [hass_pkg::SRV_W-1:0]       server_index_reg;
    logic                             fallback_reg;

    logic [hass_pkg::SRV_W-1:0]       rr_mem [hass_pkg::GROUPS];
    logic [hass_pkg::GROUPS-1:0]      vld_reg;

    logic                             accept;
    logic                             out_load;
    logic [hass_pkg::CNT_W-1:0]       cnt_sat;
    logic                             sticky_in;
    logic [hass_pkg::SRV_W-1:0]       ptr_start;
    logic [hass_pkg::SRV_W-1:0]       ptr_raw;
    logic [hass_pkg::CNT_W-1:0]       sel_inc;
    logic                             ptr_wr;
    logic [hass_pkg::SRV_W-1:0]       ptr_wdata;

    hass_pkg::mod_cmd_t               mod_cmd;
    hass_pkg::mod_res_t               mod_res;
    hass_pkg::scan_cmd_t              scan_cmd;
    hass_pkg::scan_res_t              scan_res;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        if (server_count == '0)
        begin
            cnt_sat = hass_pkg::CNT_W'(1);
        end
        else if (server_count > hass_pkg::CNT_W'(hass_pkg::MAX_SERVERS))
        begin
            cnt_sat = hass_pkg::CNT_W'(hass_pkg::MAX_SERVERS);
        end
        else
        begin
            cnt_sat = server_count;
        end
    end

    assign sticky_in = (mode == hass_pkg::MODE_STICKY) && (client_hash != '0);

    // a group of one never scans, so the remainder is not needed
    assign mod_cmd.start = accept && sticky_in && (cnt_sat != hass_pkg::CNT_W'(1));
    assign mod_cmd.hash  = client_hash;
    assign mod_cmd.cnt   = cnt_sat;

    hass_mod u_mod
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mod_cmd),
        .res   (mod_res)
    );

    // stale pointer (not below count) restarts at server 0
    assign ptr_raw   = ptr_vld_reg ? ptr_rd_reg : '0;
    assign ptr_start = ({1'b0, ptr_raw} >= cnt_reg) ? '0 : ptr_raw;

    always_comb
    begin
        scan_cmd.start       = 1'b0;
        scan_cmd.cnt         = cnt_reg;
        scan_cmd.start_idx   = ptr_start;
        scan_cmd.allow_first = (mode_reg == hass_pkg::MODE_RR);
        scan_cmd.allow_rest  = (mode_reg == hass_pkg::MODE_RR);
        if (state_reg == ST_PREP && cnt_reg != hass_pkg::CNT_W'(1))
        begin
            if (mode_reg == hass_pkg::MODE_FAILOVER)
            begin
                scan_cmd.start       = 1'b1;
                scan_cmd.start_idx   = '0;
                scan_cmd.allow_first = 1'b1;
                scan_cmd.allow_rest  = 1'b1;
            end
            else if (sticky_reg)
            begin
                scan_cmd.start       = mod_res.done;
                scan_cmd.start_idx   = mod_res.rem;
                scan_cmd.allow_first = 1'b1;
                scan_cmd.allow_rest  = 1'b0;
            end
            else
            begin
                scan_cmd.start = 1'b1;
            end
        end
    end

    hass_scan u_scan
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (scan_cmd),
        .masks (masks_reg),
        .res   (scan_res)
    );

    // round robin, mode three and sticky with a zero hash move the group pointer past the pick
    assign sel_inc   = {1'b0, scan_res.sel} + 1'b1;
    assign ptr_wdata = (sel_inc >= cnt_reg) ? '0 : sel_inc[hass_pkg::SRV_W-1:0];
    assign ptr_wr    = (state_reg == ST_SCAN) && scan_res.done
        && (mode_reg != hass_pkg::MODE_FAILOVER) && !sticky_reg;

    always_ff @(posedge clk)
    begin
        if (ptr_wr)
        begin
            rr_mem[grp_reg] <= ptr_wdata;
        end
        if (accept)
        begin
            ptr_rd_reg <= rr_mem[group_id[hass_pkg::GROUP_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            ptr_vld_reg <= 1'b0;
        end
        else
        begin
            if (ptr_wr)
            begin
                vld_reg[grp_reg] <= 1'b1;
            end
            if (accept)
            begin
                ptr_vld_reg <= vld_reg[group_id[hass_pkg::GROUP_W-1:0]];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            grp_reg         <= group_id[hass_pkg::GROUP_W-1:0];
            cnt_reg         <= cnt_sat;
            mode_reg        <= mode;
            sticky_reg      <= sticky_in;
            masks_reg.ok    <= fail_ok_mask;
            masks_reg.fade  <= fail_fade_mask;
            masks_reg.up    <= monitor_up_mask;
            masks_reg.mfade <= monitor_fade_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            server_index_reg <= '0;
            fallback_reg     <= 1'b0;
            res_sel_reg      <= '0;
            res_fb_reg       <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    if (cnt_reg == hass_pkg::CNT_W'(1))
                    begin
                        res_sel_reg <= '0;
                        res_fb_reg  <= 1'b0;
                        state_reg   <= ST_OUT;
                    end
                    else if (scan_cmd.start)
                    begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (scan_res.done)
                    begin
                        res_sel_reg <= scan_res.sel;
                        res_fb_reg  <= scan_res.fb;
                        state_reg   <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        server_index_reg <= res_sel_reg;
                        fallback_reg     <= res_fb_reg;
                        state_reg        <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign server_index  = server_index_reg;
    assign fallback_used = fallback_reg;

    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result appeared without a finished request");

    a_scan_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_res.done |-> state_reg == ST_SCAN)
        else $error("scan finished outside the scan state");

    a_mod_in_prep: assert property (@(posedge clk) disable iff (!rst_n)
        mod_res.done |-> state_reg == ST_PREP && sticky_reg)
        else $error("remainder finished with no sticky request waiting");

    a_sel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> {1'b0, res_sel_reg} < cnt_reg)
        else $error("chosen server not below the server count");

    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_wr |-> {1'b0, ptr_wdata} < cnt_reg)
        else $error("stored pointer not below the server count");

endmodule
`default_nettype wire
